// ----- hw/rtl/due_time_priority_queue_core_macros.svh -----
// assertion macros for the due-time priority queue
// used by the top level only; no other dependencies
`ifndef DUE_TIME_PRIORITY_QUEUE_CORE_MACROS_SVH
`define DUE_TIME_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define DTPQ_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("dtpq assertion failed");
// condition holds in the cycle after the trigger
`define DTPQ_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("dtpq assertion failed");
`else
`define DTPQ_ASSERT_NOW(label, clk, rst, trig, cond)
`define DTPQ_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif

`endif

// ----- hw/rtl/dtpq_pkg.sv -----
// types and constants for the due-time priority queue
// no dependencies
package dtpq_pkg;

  localparam int TIME_W  = 64;
  localparam int ID_W    = 16;
  localparam int COUNT_W = 6;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_COLLECT  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_COLLECT
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [TIME_W-1:0] time_value;
    logic [ID_W-1:0]   job_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    released_id;
    logic               id_valid;
    logic               last;
    logic               status;
    logic               next_valid;
    logic [TIME_W-1:0]  next_time;
    logic [COUNT_W-1:0] pending_count;
  } out_item_t;

  // one queue slot
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] due_time;
    logic [ID_W-1:0]   id;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [TIME_W-1:0] new_time;
    logic [ID_W-1:0]   new_id;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/due_time_priority_queue_core.sv -----
// top level of the due-time priority queue: control, chain of cells, output register
// depends on dtpq_pkg, dtpq_cell and due_time_priority_queue_core_macros.svh
//
//   channel | signals                     | payload
//   --------+-----------------------------+------------
//   in      | in_valid, in_ready, in_data | in_item_t
//   out     | out_valid, out_ready, out_data | out_item_t
//
// a schedule item is captured in ST_IDLE, then inserted into the chain in ST_SCHED
// a collect item releases at most one id per result: the chain pops one entry per
//   cycle while the output register is free, since only the head slot decides a release
// reset clears the valid bit of every cell, the count and the state; no clearing pass
// a result waits in the output register; the next item is captured meanwhile, and
//   work on it stalls only while the output register is still full
`include "due_time_priority_queue_core_macros.svh"

module due_time_priority_queue_core
  import dtpq_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state;
  state_t state_next;

  // captured item
  logic [TIME_W-1:0] hold_time;
  logic [ID_W-1:0]   hold_id;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  cell_ctrl_t ctrl;
  entry_t     cell_q [CAPACITY];
  logic       cell_gt [CAPACITY];

  logic      out_free;
  logic      load;
  out_item_t result;
  logic      full;
  logic      head_due;
  logic      second_due;

  assign out_free   = !out_valid || out_ready;
  assign full       = (count == CNT_W'(CAPACITY));
  assign head_due   = cell_q[0].valid && (cell_q[0].due_time <= hold_time);
  assign second_due = cell_q[1].valid && (cell_q[1].due_time <= hold_time);

  // the chain: each cell sees its neighbors; the left end looks like a filled slot
  // holding an earlier time, the right end like an empty slot
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_g;

    if (i == 0) begin : g_left_end
      assign left_e = '{valid: 1'b1, due_time: '0, id: '0};
      assign left_g = 1'b0;
    end else begin : g_left
      assign left_e = cell_q[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_end
      assign right_e = '0;
    end else begin : g_right
      assign right_e = cell_q[i+1];
    end

    dtpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .gt          (cell_gt[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.operation == OP_COLLECT) ? ST_COLLECT : ST_SCHED;
        end
      end
      ST_SCHED: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_COLLECT: begin
        // stop after a miss or when the next head is not due
        if (out_free && (!head_due || !second_due)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready      = 1'b0;
    load          = 1'b0;
    ctrl.insert   = 1'b0;
    ctrl.pop      = 1'b0;
    ctrl.new_time = hold_time;
    ctrl.new_id   = hold_id;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCHED: begin
        load        = out_free;
        ctrl.insert = out_free && !full;
      end
      ST_COLLECT: begin
        load     = out_free;
        ctrl.pop = out_free && head_due;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result fields, as the queue stands after this step
  always_comb begin
    result     = '0;
    count_next = count;
    if (state == ST_SCHED) begin
      result.last   = 1'b1;
      result.status = full;
      if (!full) begin
        count_next = count + CNT_W'(1);
      end
      if (full) begin
        result.next_valid = 1'b1;
        result.next_time  = cell_q[0].due_time;
      end else if (!cell_q[0].valid || (hold_time < cell_q[0].due_time)) begin
        result.next_valid = 1'b1;
        result.next_time  = hold_time;
      end else begin
        result.next_valid = 1'b1;
        result.next_time  = cell_q[0].due_time;
      end
    end else if (head_due) begin
      // release the head; the second slot becomes the new head
      count_next         = count - CNT_W'(1);
      result.released_id = cell_q[0].id;
      result.id_valid    = 1'b1;
      result.last        = !second_due;
      result.next_valid  = cell_q[1].valid;
      result.next_time   = cell_q[1].valid ? cell_q[1].due_time : '0;
    end else begin
      // nothing due
      result.last       = 1'b1;
      result.next_valid = cell_q[0].valid;
      result.next_time  = cell_q[0].valid ? cell_q[0].due_time : '0;
    end
    result.pending_count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_time <= in_data.time_value;
      hold_id   <= in_data.job_id;
    end
    if (load) begin
      out_data <= result;
    end
  end

  // the count tracks the head slot and never passes the capacity
  `DTPQ_ASSERT_NOW(a_count_head, clk, rst, 1'b1, (count != '0) == cell_q[0].valid)
  `DTPQ_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  // an insert never pushes an entry off the tail
  `DTPQ_ASSERT_NOW(a_no_overflow, clk, rst, ctrl.insert, !cell_q[CAPACITY-1].valid)
  // a pop always removes exactly one entry
  `DTPQ_ASSERT_NEXT(a_pop_count, clk, rst, ctrl.pop, count == $past(count) - CNT_W'(1))

endmodule

// ----- hw/rtl/dtpq_cell.sv -----
// one slot of the sorted shift chain
// depends on dtpq_pkg
module dtpq_cell
  import dtpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left_entry,
  input  logic       left_gt,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       gt
);

  entry_t entry_next;

  // slot holds a later time than the one being inserted
  assign gt = entry.valid && (entry.due_time > ctrl.new_time);

  always_comb begin
    entry_next = entry;
    priority if (ctrl.pop) begin
      entry_next = right_entry;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        entry_next = left_entry;
      end else if ((!entry.valid || gt) && left_entry.valid) begin
        entry_next.valid    = 1'b1;
        entry_next.due_time = ctrl.new_time;
        entry_next.id       = ctrl.new_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    entry.due_time <= entry_next.due_time;
    entry.id       <= entry_next.id;
  end

endmodule
